[rtl/plob_pkg.sv]
// Shared types and constants for the price level order book.
`timescale 1ns / 1ps

package plob_pkg;

   localparam int ID_W    = 12;
   localparam int PRICE_W = 32;
   localparam int QTY_W   = 31;
   localparam int LVL_W   = 6;
   localparam int STAT_W  = 2;

   // order table word: live, side, price, size
   localparam int ORDER_WORD_W = 2 + PRICE_W + QTY_W;

   localparam logic [QTY_W-1:0] SIZE_MAX = {QTY_W{1'b1}};

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_MODIFY = 2'd1,
      OP_REMOVE = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_FULL    = 2'd2,
      ST_LIVE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_CLEAR = 2'd0,
      FSM_IDLE  = 2'd1,
      FSM_EXEC  = 2'd2
   } fsm_type;

   typedef enum logic [2:0] {
      CELL_HOLD    = 3'd0,
      CELL_ADD_HIT = 3'd1,
      CELL_ADD_NEW = 3'd2,
      CELL_MODIFY  = 3'd3,
      CELL_REMOVE  = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [PRICE_W-1:0]      price;
      logic [QTY_W-1:0]        qty;
      logic [QTY_W-1:0]        old_size;
   } cell_cmd_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [ID_W-1:0]    order_tag;
      logic               side;
      logic [PRICE_W-1:0] price_ticks;
      logic [QTY_W-1:0]   quantity;
      logic [LVL_W-1:0]   level_number;
   } req_type;

endpackage

[rtl/plob_req_if.sv]
// Request channel interface: one order book transaction per handshake.
`timescale 1ns / 1ps

interface plob_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     opcode;
   logic [plob_pkg::ID_W-1:0]      order_tag;
   logic                           side;
   logic [plob_pkg::PRICE_W-1:0]   price_ticks;
   logic [plob_pkg::QTY_W-1:0]     quantity;
   logic [plob_pkg::LVL_W-1:0]     level_number;

   modport source (output valid, opcode, order_tag, side, price_ticks, quantity,
                   level_number, input ready);
   modport sink   (input valid, opcode, order_tag, side, price_ticks, quantity,
                   level_number, output ready);
endinterface

[rtl/plob_rsp_if.sv]
// Response channel interface: one result per request transaction.
`timescale 1ns / 1ps

interface plob_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [plob_pkg::STAT_W-1:0]    status;
   logic [plob_pkg::PRICE_W-1:0]   level_price;
   logic [plob_pkg::QTY_W-1:0]     level_size;

   modport source (output valid, status, level_price, level_size, input ready);
   modport sink   (input valid, status, level_price, level_size, output ready);
endinterface

[rtl/plob_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module plob_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/plob_cell.sv]
// One price level cell; shifts toward its neighbors on insert and close.
`timescale 1ns / 1ps

module plob_cell #(
   parameter int   COUNT_W = 13,
   parameter int   TOTAL_W = 44,
   parameter logic IS_ASK  = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  plob_pkg::cell_cmd_type        cmd,
   input  logic                          close_level,
   // neighbor toward the best price
   input  logic                          left_valid,
   input  logic [plob_pkg::PRICE_W-1:0]  left_price,
   input  logic [TOTAL_W-1:0]            left_total,
   input  logic [COUNT_W-1:0]            left_count,
   input  logic                          left_after,
   input  logic                          left_rm,
   // neighbor toward the worse price
   input  logic                          right_valid,
   input  logic [plob_pkg::PRICE_W-1:0]  right_price,
   input  logic [TOTAL_W-1:0]            right_total,
   input  logic [COUNT_W-1:0]            right_count,
   output logic                          valid,
   output logic [plob_pkg::PRICE_W-1:0]  price,
   output logic [TOTAL_W-1:0]            total,
   output logic [COUNT_W-1:0]            count,
   output logic                          match,
   output logic                          after,
   output logic                          rm,
   output logic                          closing
);

   logic                         valid_ff, valid_in;
   logic [plob_pkg::PRICE_W-1:0] price_ff, price_in;
   logic [TOTAL_W-1:0]           total_ff, total_in;
   logic [COUNT_W-1:0]           count_ff, count_in;
   logic                         better;

   assign better  = IS_ASK ? (cmd.price < price_ff) : (cmd.price > price_ff);
   assign match   = valid_ff && (price_ff == cmd.price);
   // new price belongs somewhere behind this level
   assign after   = valid_ff && !better;
   assign rm      = match || left_rm;
   assign closing = match && (count_ff == '0 || count_ff == COUNT_W'(1));

   always_comb begin
      valid_in = valid_ff;
      price_in = price_ff;
      total_in = total_ff;
      count_in = count_ff;
      unique case (cmd.op)
         plob_pkg::CELL_HOLD: begin
         end
         plob_pkg::CELL_ADD_HIT: begin
            if (match) begin
               total_in = total_ff + TOTAL_W'(cmd.qty);
               count_in = count_ff + COUNT_W'(1);
            end
         end
         plob_pkg::CELL_ADD_NEW: begin
            if (!after) begin
               if (left_after) begin
                  valid_in = 1'b1;
                  price_in = cmd.price;
                  total_in = TOTAL_W'(cmd.qty);
                  count_in = COUNT_W'(1);
               end else begin
                  valid_in = left_valid;
                  price_in = left_price;
                  total_in = left_total;
                  count_in = left_count;
               end
            end
         end
         plob_pkg::CELL_MODIFY: begin
            if (match) begin
               total_in = total_ff - TOTAL_W'(cmd.old_size) + TOTAL_W'(cmd.qty);
            end
         end
         plob_pkg::CELL_REMOVE: begin
            if (close_level) begin
               if (rm) begin
                  valid_in = right_valid;
                  price_in = right_price;
                  total_in = right_total;
                  count_in = right_count;
               end
            end else if (match) begin
               total_in = total_ff - TOTAL_W'(cmd.old_size);
               count_in = (count_ff != '0) ? count_ff - COUNT_W'(1) : count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      price_ff <= price_in;
      total_ff <= total_in;
      count_ff <= count_in;
   end

   assign valid = valid_ff;
   assign price = price_ff;
   assign total = total_ff;
   assign count = count_ff;

endmodule

[rtl/price_level_order_book.sv]
// Price level order book: bid and ask sides as chains of level cells.
// A request is taken with its order table read; the table update and the response follow
// once the result slot is free. No request is taken until the current one completes.
// Reset: synchronous; a clearing pass zeroes each of the ORDER_SLOTS order table words,
// during which no request is taken. All price levels are empty after reset.
`timescale 1ns / 1ps

module price_level_order_book #(
   parameter int ORDER_SLOTS     = 4096,
   parameter int LEVELS_PER_SIDE = 32
) (
   input  logic            clock,
   input  logic            reset,
   plob_req_if.sink        req_ch,
   plob_rsp_if.source      rsp_ch
);

   localparam int ADDR_W   = $clog2(ORDER_SLOTS);
   localparam int IDEXT_W  = (ADDR_W > plob_pkg::ID_W) ? ADDR_W : plob_pkg::ID_W;
   localparam int COUNT_W  = $clog2(ORDER_SLOTS + 1);
   localparam int TOTAL_W  = plob_pkg::QTY_W + COUNT_W;
   localparam int IDX_W    = $clog2(LEVELS_PER_SIDE);
   localparam int SEL_W    = (IDX_W > plob_pkg::LVL_W) ? IDX_W : plob_pkg::LVL_W;
   localparam int PW       = plob_pkg::PRICE_W;
   localparam int QW       = plob_pkg::QTY_W;

   // ---------------------------------------------------------------
   // control state
   // ---------------------------------------------------------------
   plob_pkg::fsm_type    state_ff, state_in;
   logic [ADDR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   plob_pkg::req_type    req_ff, req_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [plob_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PW-1:0]        rsp_price_ff, rsp_price_in;
   logic [QW-1:0]        rsp_size_ff, rsp_size_in;

   logic req_take;
   logic complete;

   assign req_ch.ready = (state_ff == plob_pkg::FSM_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   // result slot free or draining this cycle
   assign complete     = (state_ff == plob_pkg::FSM_EXEC) &&
                         (!rsp_valid_ff || rsp_ch.ready);

   // ---------------------------------------------------------------
   // order table: {live, side, price, size}
   // ---------------------------------------------------------------
   logic                              ram_we;
   logic [ADDR_W-1:0]                 ram_waddr;
   logic [plob_pkg::ORDER_WORD_W-1:0] ram_wdata;
   logic [ADDR_W-1:0]                 ram_raddr;
   logic [plob_pkg::ORDER_WORD_W-1:0] ram_rdata;
   logic [IDEXT_W-1:0]                rd_id_ext;
   logic [IDEXT_W-1:0]                ex_id_ext;

   assign rd_id_ext = (state_ff == plob_pkg::FSM_IDLE) ? IDEXT_W'(req_ch.order_tag)
                                                        : IDEXT_W'(req_ff.order_tag);
   assign ex_id_ext = IDEXT_W'(req_ff.order_tag);
   assign ram_raddr = rd_id_ext[ADDR_W-1:0];

   plob_ram #(
      .WIDTH (plob_pkg::ORDER_WORD_W),
      .DEPTH (ORDER_SLOTS)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic          ord_live;
   logic          ord_side;
   logic [PW-1:0] ord_price;
   logic [QW-1:0] ord_size;
   logic          id_ok;

   assign ord_live  = ram_rdata[plob_pkg::ORDER_WORD_W-1];
   assign ord_side  = ram_rdata[plob_pkg::ORDER_WORD_W-2];
   assign ord_price = ram_rdata[QW +: PW];
   assign ord_size  = ram_rdata[QW-1:0];
   assign id_ok     = 32'(req_ff.order_tag) < 32'(ORDER_SLOTS);

   // ---------------------------------------------------------------
   // level cell chains, one per side (0 bid, 1 ask)
   // ---------------------------------------------------------------
   plob_pkg::cell_cmd_type cmd_side [2];
   logic                   close_side [2];

   logic               c_valid [2][LEVELS_PER_SIDE];
   logic [PW-1:0]      c_price [2][LEVELS_PER_SIDE];
   logic [TOTAL_W-1:0] c_total [2][LEVELS_PER_SIDE];
   logic [COUNT_W-1:0] c_count [2][LEVELS_PER_SIDE];
   logic               c_match [2][LEVELS_PER_SIDE];
   logic               c_after [2][LEVELS_PER_SIDE];
   logic               c_rm    [2][LEVELS_PER_SIDE];
   logic               c_close [2][LEVELS_PER_SIDE];

   for (genvar s = 0; s < 2; s++) begin : g_side
      for (genvar i = 0; i < LEVELS_PER_SIDE; i++) begin : g_cell
         logic               l_valid, l_after, l_rm, r_valid;
         logic [PW-1:0]      l_price, r_price;
         logic [TOTAL_W-1:0] l_total, r_total;
         logic [COUNT_W-1:0] l_count, r_count;

         if (i == 0) begin : g_head
            // insert at the head when no level ranks ahead
            assign l_valid = 1'b0;
            assign l_price = '0;
            assign l_total = '0;
            assign l_count = '0;
            assign l_after = 1'b1;
            assign l_rm    = 1'b0;
         end else begin : g_mid
            assign l_valid = c_valid[s][i-1];
            assign l_price = c_price[s][i-1];
            assign l_total = c_total[s][i-1];
            assign l_count = c_count[s][i-1];
            assign l_after = c_after[s][i-1];
            assign l_rm    = c_rm[s][i-1];
         end

         if (i == LEVELS_PER_SIDE - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_price = '0;
            assign r_total = '0;
            assign r_count = '0;
         end else begin : g_body
            assign r_valid = c_valid[s][i+1];
            assign r_price = c_price[s][i+1];
            assign r_total = c_total[s][i+1];
            assign r_count = c_count[s][i+1];
         end

         plob_cell #(
            .COUNT_W (COUNT_W),
            .TOTAL_W (TOTAL_W),
            .IS_ASK  (1'(s))
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd_side[s]),
            .close_level (close_side[s]),
            .left_valid  (l_valid),
            .left_price  (l_price),
            .left_total  (l_total),
            .left_count  (l_count),
            .left_after  (l_after),
            .left_rm     (l_rm),
            .right_valid (r_valid),
            .right_price (r_price),
            .right_total (r_total),
            .right_count (r_count),
            .valid       (c_valid[s][i]),
            .price       (c_price[s][i]),
            .total       (c_total[s][i]),
            .count       (c_count[s][i]),
            .match       (c_match[s][i]),
            .after       (c_after[s][i]),
            .rm          (c_rm[s][i]),
            .closing     (c_close[s][i])
         );
      end
   end

   // per side: price hit anywhere, and whether the hit level empties
   logic hit_side [2];
   logic last_side [2];

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         hit_side[s]  = 1'b0;
         last_side[s] = 1'b0;
         for (int i = 0; i < LEVELS_PER_SIDE; i++) begin
            hit_side[s]  = hit_side[s] | c_match[s][i];
            last_side[s] = last_side[s] | c_close[s][i];
         end
      end
   end

   // ---------------------------------------------------------------
   // execute decode
   // ---------------------------------------------------------------
   logic                  sel_side;
   logic                  sel_full;
   logic                  sel_hit;
   plob_pkg::cell_cmd_type ex_cmd;
   plob_pkg::status_type  ex_status;

   always_comb begin
      sel_side = (req_ff.opcode == plob_pkg::OP_ADD || req_ff.opcode == plob_pkg::OP_QUERY)
                 ? req_ff.side : ord_side;
      sel_full = c_valid[sel_side][LEVELS_PER_SIDE-1];
      sel_hit  = hit_side[sel_side];

      ex_cmd.op       = plob_pkg::CELL_HOLD;
      ex_cmd.price    = (req_ff.opcode == plob_pkg::OP_ADD) ? req_ff.price_ticks : ord_price;
      ex_cmd.qty      = req_ff.quantity;
      ex_cmd.old_size = ord_size;
      ex_status       = plob_pkg::ST_OK;

      unique case (plob_pkg::op_type'(req_ff.opcode))
         plob_pkg::OP_ADD: begin
            priority if (!id_ok) begin
               ex_status = plob_pkg::ST_UNKNOWN;
            end else if (ord_live) begin
               ex_status = plob_pkg::ST_LIVE;
            end else if (sel_hit) begin
               ex_cmd.op = plob_pkg::CELL_ADD_HIT;
            end else if (sel_full) begin
               ex_status = plob_pkg::ST_FULL;
            end else begin
               ex_cmd.op = plob_pkg::CELL_ADD_NEW;
            end
         end
         plob_pkg::OP_MODIFY: begin
            if (!id_ok || !ord_live) begin
               ex_status = plob_pkg::ST_UNKNOWN;
            end else begin
               ex_cmd.op = plob_pkg::CELL_MODIFY;
            end
         end
         plob_pkg::OP_REMOVE: begin
            if (!id_ok || !ord_live) begin
               ex_status = plob_pkg::ST_UNKNOWN;
            end else begin
               ex_cmd.op = plob_pkg::CELL_REMOVE;
            end
         end
         plob_pkg::OP_QUERY: begin
         end
         default: begin
         end
      endcase
   end

   // commands reach only the addressed side, and only on completion
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         cmd_side[s]    = ex_cmd;
         close_side[s]  = last_side[s];
         if (!complete || (sel_side != 1'(s))) begin
            cmd_side[s].op = plob_pkg::CELL_HOLD;
         end
      end
   end

   // query read-out, 1-based level
   logic [SEL_W-1:0]   lvl_m1;
   logic [IDX_W-1:0]   q_idx;
   logic               q_ok;
   logic [TOTAL_W-1:0] q_total;

   assign lvl_m1  = SEL_W'(req_ff.level_number) - SEL_W'(1);
   assign q_idx   = lvl_m1[IDX_W-1:0];
   assign q_ok    = (req_ff.level_number != '0) &&
                    (32'(req_ff.level_number) <= 32'(LEVELS_PER_SIDE)) &&
                    c_valid[req_ff.side][q_idx];
   assign q_total = c_total[req_ff.side][q_idx];

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      req_in        = req_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_price_in  = rsp_price_ff;
      rsp_size_in   = rsp_size_ff;
      ram_we        = 1'b0;
      ram_waddr     = ex_id_ext[ADDR_W-1:0];
      ram_wdata     = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         plob_pkg::FSM_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(ORDER_SLOTS - 1)) begin
               state_in = plob_pkg::FSM_IDLE;
            end
         end
         plob_pkg::FSM_IDLE: begin
            if (req_take) begin
               req_in.opcode       = req_ch.opcode;
               req_in.order_tag    = req_ch.order_tag;
               req_in.side         = req_ch.side;
               req_in.price_ticks  = req_ch.price_ticks;
               req_in.quantity     = req_ch.quantity;
               req_in.level_number = req_ch.level_number;
               state_in            = plob_pkg::FSM_EXEC;
            end
         end
         plob_pkg::FSM_EXEC: begin
            if (complete) begin
               state_in      = plob_pkg::FSM_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ex_status;
               rsp_price_in  = '0;
               rsp_size_in   = '0;
               if (req_ff.opcode == plob_pkg::OP_QUERY) begin
                  if (q_ok) begin
                     rsp_price_in = c_price[req_ff.side][q_idx];
                     rsp_size_in  = (q_total > TOTAL_W'(plob_pkg::SIZE_MAX))
                                    ? plob_pkg::SIZE_MAX : q_total[QW-1:0];
                  end
               end else if (ex_status == plob_pkg::ST_OK) begin
                  ram_we = 1'b1;
                  unique case (plob_pkg::op_type'(req_ff.opcode))
                     plob_pkg::OP_ADD:
                        ram_wdata = {1'b1, req_ff.side, req_ff.price_ticks, req_ff.quantity};
                     plob_pkg::OP_MODIFY:
                        ram_wdata = {1'b1, ord_side, ord_price, req_ff.quantity};
                     default:
                        ram_wdata = '0;
                  endcase
               end
            end
         end
         default: begin
            state_in = plob_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plob_pkg::FSM_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      rsp_status_ff <= rsp_status_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.level_price = rsp_price_ff;
   assign rsp_ch.level_size  = rsp_size_ff;

endmodule

[sim/price_level_order_book_checker.sv]
// Checker: watches request and response channels, predicts the order book and compares.
`timescale 1ns / 1ps

module price_level_order_book_checker #(
   parameter int LEVELS_PER_SIDE = 32
) (
   input  logic       clock,
   input  logic       reset,
   plob_req_if        req_ch,
   plob_rsp_if        rsp_ch,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      logic [plob_pkg::STAT_W-1:0]  status;
      logic [plob_pkg::PRICE_W-1:0] price;
      logic [plob_pkg::QTY_W-1:0]   size;
   } book_rsp_type;

   // book model state
   logic                         ord_live [4096];
   logic                         ord_side [4096];
   logic [plob_pkg::PRICE_W-1:0] ord_price [4096];
   logic [plob_pkg::QTY_W-1:0]   ord_size [4096];
   logic [plob_pkg::PRICE_W-1:0] lvl_price [2][LEVELS_PER_SIDE];
   logic [43:0]                  lvl_total [2][LEVELS_PER_SIDE];
   logic [12:0]                  lvl_orders [2][LEVELS_PER_SIDE];
   int                           lvl_used [2];

   book_rsp_type answer_q[$];

   function automatic int find_level(logic s, logic [plob_pkg::PRICE_W-1:0] p);
      for (int i = 0; i < lvl_used[s]; i++)
         if (lvl_price[s][i] == p) return i;
      return -1;
   endfunction

   function automatic book_rsp_type book_apply(plob_pkg::req_type r);
      book_rsp_type res;
      int           lv, pos;
      logic         s;
      res = '0;
      s = r.side;
      case (plob_pkg::op_type'(r.opcode))
         plob_pkg::OP_ADD: begin
            if (ord_live[r.order_tag]) begin
               res.status = plob_pkg::ST_LIVE;
            end else begin
               lv = find_level(s, r.price_ticks);
               if (lv >= 0) begin
                  lvl_total[s][lv] += r.quantity;
                  lvl_orders[s][lv] += 1;
               end else if (lvl_used[s] >= LEVELS_PER_SIDE) begin
                  res.status = plob_pkg::ST_FULL;
                  return res;
               end else begin
                  pos = 0;
                  while (pos < lvl_used[s] && !(s == 1'b0 ?
                         r.price_ticks > lvl_price[s][pos] :
                         r.price_ticks < lvl_price[s][pos]))
                     pos++;
                  for (int k = lvl_used[s]; k > pos; k--) begin
                     lvl_price[s][k] = lvl_price[s][k-1];
                     lvl_total[s][k] = lvl_total[s][k-1];
                     lvl_orders[s][k] = lvl_orders[s][k-1];
                  end
                  lvl_price[s][pos] = r.price_ticks;
                  lvl_total[s][pos] = 44'(r.quantity);
                  lvl_orders[s][pos] = 1;
                  lvl_used[s]++;
               end
               ord_live[r.order_tag] = 1'b1;
               ord_side[r.order_tag] = s;
               ord_price[r.order_tag] = r.price_ticks;
               ord_size[r.order_tag] = r.quantity;
            end
         end
         plob_pkg::OP_MODIFY: begin
            if (!ord_live[r.order_tag]) begin
               res.status = plob_pkg::ST_UNKNOWN;
            end else begin
               s = ord_side[r.order_tag];
               lv = find_level(s, ord_price[r.order_tag]);
               if (lv >= 0)
                  lvl_total[s][lv] = lvl_total[s][lv] - ord_size[r.order_tag] + r.quantity;
               ord_size[r.order_tag] = r.quantity;
            end
         end
         plob_pkg::OP_REMOVE: begin
            if (!ord_live[r.order_tag]) begin
               res.status = plob_pkg::ST_UNKNOWN;
            end else begin
               s = ord_side[r.order_tag];
               lv = find_level(s, ord_price[r.order_tag]);
               ord_live[r.order_tag] = 1'b0;
               if (lv >= 0) begin
                  lvl_total[s][lv] -= ord_size[r.order_tag];
                  if (lvl_orders[s][lv] > 0) lvl_orders[s][lv] -= 1;
                  if (lvl_orders[s][lv] == 0) begin
                     for (int k = lv; k + 1 < lvl_used[s]; k++) begin
                        lvl_price[s][k] = lvl_price[s][k+1];
                        lvl_total[s][k] = lvl_total[s][k+1];
                        lvl_orders[s][k] = lvl_orders[s][k+1];
                     end
                     lvl_used[s]--;
                  end
               end
            end
         end
         default: begin
            if (r.level_number >= 1 && r.level_number <= lvl_used[s]) begin
               res.price = lvl_price[s][r.level_number-1];
               res.size = (lvl_total[s][r.level_number-1] > 44'(plob_pkg::SIZE_MAX)) ?
                          plob_pkg::SIZE_MAX : lvl_total[s][r.level_number-1][plob_pkg::QTY_W-1:0];
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      plob_pkg::req_type r;
      book_rsp_type      want;
      if (reset) begin
         fail_count <= 0;
         answer_q.delete();
         lvl_used[0] = 0;
         lvl_used[1] = 0;
         for (int i = 0; i < 4096; i++) ord_live[i] = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            r = '{req_ch.opcode, req_ch.order_tag, req_ch.side, req_ch.price_ticks,
                  req_ch.quantity, req_ch.level_number};
            answer_q.insert(answer_q.size(), book_apply(r));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: response with none expected: actual %h/%h/%h", $time,
                        rsp_ch.status, rsp_ch.level_price, rsp_ch.level_size);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_q.pop_front();
               if (want.status !== rsp_ch.status || want.price !== rsp_ch.level_price ||
                   want.size !== rsp_ch.level_size) begin
                  $display("%0t: mismatch expected %h/%h/%h actual %h/%h/%h", $time,
                           want.status, want.price, want.size, rsp_ch.status,
                           rsp_ch.level_price, rsp_ch.level_size);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= answer_q.size();
   end

endmodule

[sim/price_level_order_book_tb.sv]
// Testbench top: drives order book transactions and reports the verdict.
`timescale 1ns / 1ps

module price_level_order_book_tb;

   localparam int LEVELS = 32;
   localparam int CYCLE_LIMIT = 900000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   int   cycle_count = 0;

   plob_req_if req_ch ();
   plob_rsp_if rsp_ch ();

   price_level_order_book #(.ORDER_SLOTS(4096), .LEVELS_PER_SIDE(LEVELS)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   price_level_order_book_checker #(.LEVELS_PER_SIDE(LEVELS)) book_chk (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hard stop against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response side: random stall before each transaction, sometimes none at all
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock iff rsp_ch.valid);
      end
   end

   // prices kept in a narrow band so levels collide, fill and empty often
   logic [plob_pkg::PRICE_W-1:0] base_px;

   task automatic send_txn(plob_pkg::op_type op, logic [plob_pkg::ID_W-1:0] id, logic sd,
                           logic [plob_pkg::PRICE_W-1:0] px,
                           logic [plob_pkg::QTY_W-1:0] qty,
                           logic [plob_pkg::LVL_W-1:0] lvl, bit no_gap = 0);
      int gap;
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.order_tag    <= id;
      req_ch.side         <= sd;
      req_ch.price_ticks  <= px;
      req_ch.quantity     <= qty;
      req_ch.level_number <= lvl;
      @(posedge clock iff req_ch.ready);
   endtask

   function automatic logic [plob_pkg::PRICE_W-1:0] pick_price();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return {plob_pkg::PRICE_W{1'b1}} - $urandom_range(0, 3);
         2:       return $urandom_range(0, 3);
         default: return base_px + $urandom_range(0, 40);
      endcase
   endfunction

   function automatic logic [plob_pkg::QTY_W-1:0] pick_qty();
      case ($urandom_range(0, 5))
         0:       return plob_pkg::QTY_W'(plob_pkg::SIZE_MAX - $urandom_range(0, 2));
         1:       return plob_pkg::QTY_W'($urandom());
         2:       return '0;
         default: return plob_pkg::QTY_W'($urandom_range(1, 1000));
      endcase
   endfunction

   initial begin
      int id_lo;
      req_ch.valid = 1'b0;
      req_ch.opcode = plob_pkg::OP_QUERY;
      req_ch.order_tag = '0;
      req_ch.side = 1'b0;
      req_ch.price_ticks = '0;
      req_ch.quantity = '0;
      req_ch.level_number = '0;
      base_px = 32'h8000_0000;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each opcode and each corner of the book
      send_txn(plob_pkg::OP_QUERY, 0, 0, 0, 0, 1);               // empty book
      send_txn(plob_pkg::OP_ADD, 0, 0, '1, plob_pkg::SIZE_MAX, 0);
      send_txn(plob_pkg::OP_ADD, 12'hFFF, 0, '1, plob_pkg::SIZE_MAX, 0); // same level, saturates
      send_txn(plob_pkg::OP_ADD, 0, 1, 5, 1, 0);                  // id already live
      send_txn(plob_pkg::OP_ADD, 1, 1, 0, 7, 0);
      send_txn(plob_pkg::OP_ADD, 2, 1, 9, 3, 0);
      send_txn(plob_pkg::OP_ADD, 3, 0, 100, 2, 0);
      send_txn(plob_pkg::OP_QUERY, 0, 0, 0, 0, 1);
      send_txn(plob_pkg::OP_QUERY, 0, 0, 0, 0, 2);
      send_txn(plob_pkg::OP_QUERY, 0, 1, 0, 0, 2);
      send_txn(plob_pkg::OP_QUERY, 0, 1, 0, 0, 0);               // level zero
      send_txn(plob_pkg::OP_QUERY, 0, 1, 0, 0, 63);              // beyond levels in use
      send_txn(plob_pkg::OP_MODIFY, 1, 0, 0, 0, 0);              // modify to zero size
      send_txn(plob_pkg::OP_MODIFY, 77, 0, 0, 5, 0);             // unknown id
      send_txn(plob_pkg::OP_REMOVE, 77, 0, 0, 0, 0);
      send_txn(plob_pkg::OP_REMOVE, 0, 0, 0, 0, 0);
      send_txn(plob_pkg::OP_REMOVE, 12'hFFF, 0, 0, 0, 0);        // level closes
      send_txn(plob_pkg::OP_REMOVE, 1, 0, 0, 0, 0);              // worse levels move up
      send_txn(plob_pkg::OP_QUERY, 0, 1, 0, 0, 1);
      // fill the bid side past its limit, back to back
      for (int i = 0; i < LEVELS + 2; i++)
         send_txn(plob_pkg::OP_ADD, 12'(100 + i), 0, 32'(1000 + i * 3), 10, 0, 1);
      send_txn(plob_pkg::OP_QUERY, 0, 0, 0, 0, 6'(LEVELS));
      for (int i = 0; i < LEVELS + 2; i++)
         send_txn(plob_pkg::OP_REMOVE, 12'(100 + i), 0, 0, 0, 0, i[0]);

      // random: mostly live ids in a small pool so modify/remove hit
      id_lo = 200;
      for (int n = 0; n < 1500; n++) begin
         logic [plob_pkg::ID_W-1:0] id;
         if (n % 300 == 0) base_px = $urandom();
         id = ($urandom_range(0, 9) == 0) ? plob_pkg::ID_W'($urandom()) :
              plob_pkg::ID_W'(id_lo + $urandom_range(0, 60));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_txn(plob_pkg::OP_ADD, id, 1'($urandom_range(0, 1)),
                                 pick_price(), pick_qty(), plob_pkg::LVL_W'($urandom()));
            4:          send_txn(plob_pkg::OP_MODIFY, id, 1'($urandom_range(0, 1)),
                                 $urandom(), pick_qty(), plob_pkg::LVL_W'($urandom()));
            5, 6:       send_txn(plob_pkg::OP_REMOVE, id, 1'($urandom_range(0, 1)),
                                 $urandom(), pick_qty(), plob_pkg::LVL_W'($urandom()));
            default:    send_txn(plob_pkg::OP_QUERY, id, 1'($urandom_range(0, 1)),
                                 $urandom(), pick_qty(), ($urandom_range(0, 7) == 0) ?
                                 plob_pkg::LVL_W'($urandom()) :
                                 plob_pkg::LVL_W'($urandom_range(0, 12)));
         endcase
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
